// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the interrupt dispatch RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle property violated");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle property violated");

`endif

// ===== sv/pmid_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmid_pkg
// Types and constants shared by the priority masked interrupt dispatch block.
// ----------------------------------------------------------------------------
package pmid_pkg;

   localparam int WORD_W  = 64;
   localparam int LINE_W  = 6;
   localparam int LEVEL_W = 4;
   localparam int CMD_W   = 2;

   // Command codes.
   localparam logic [CMD_W-1:0] CMD_REGISTER  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_SET_LEVEL = 2'd1;
   localparam logic [CMD_W-1:0] CMD_EVENT     = 2'd2;

   // Named priority levels; all but none take part in the mask cascade.
   localparam logic [LEVEL_W-1:0] LVL_NONE  = 4'd0;
   localparam logic [LEVEL_W-1:0] LVL_BIO   = 4'd2;
   localparam logic [LEVEL_W-1:0] LVL_NET   = 4'd3;
   localparam logic [LEVEL_W-1:0] LVL_TTY   = 4'd4;
   localparam logic [LEVEL_W-1:0] LVL_VM    = 4'd5;
   localparam logic [LEVEL_W-1:0] LVL_CLOCK = 4'd7;
   localparam logic [LEVEL_W-1:0] LVL_HIGH  = 4'd8;
   localparam logic [LEVEL_W-1:0] LVL_IPI   = 4'd9;

   typedef enum logic [2:0] {
      KIND_ACK        = 3'd0,
      KIND_ENABLE     = 3'd1,
      KIND_SERVICE    = 3'd2,
      KIND_NOT_OURS   = 3'd3,
      KIND_ALL_MASKED = 3'd4
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SWEEP,
      ST_LEVEL,
      ST_EVENT,
      ST_SCAN
   } state_type;

   // Control side of the level mask memory port.
   typedef struct packed {
      logic               rd_en;
      logic [LEVEL_W-1:0] rd_addr;
      logic               wr_en;
      logic [LEVEL_W-1:0] wr_addr;
   } mem_ctl_type;

   // Status from the service line scanner.
   typedef struct packed {
      logic              busy;
      logic              valid;
      logic              last;
      logic [LINE_W-1:0] line;
   } scan_out_type;

endpackage

// ===== sv/priority_masked_interrupt_dispatch.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// priority_masked_interrupt_dispatch
// Interrupt controller with per-level line masks held in a small memory,
// an established line set and an enable register.
//
//   Channel   Ports                     Handshake
//   request   req_*                     start high while busy low
//   response  rsp_*                     rsp_valid strobe, one cycle per result
//
// Register commands sweep the mask memory, reading one level and writing
// back the previous one each cycle, and stay busy until the sweep ends.
// Set-level commands wait for the registered mask memory read.
// Events answer from idle when nothing is active, after the mask read
// when everything is masked, and otherwise as the scanner walks the
// lines one per cycle, giving one response per remaining active line.
// Responses are registered and cannot be stalled.
// Synchronous active-high reset clears the masks, the sets and all control.
// ----------------------------------------------------------------------------
module priority_masked_interrupt_dispatch
   import pmid_pkg::*;
#(
   parameter int NUM_LINES  = 64,
   parameter int NUM_LEVELS = 10
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [CMD_W-1:0]    req_cmd,
   input  logic [LINE_W-1:0]   req_line,
   input  logic [LEVEL_W-1:0]  req_priority_level,
   input  logic [WORD_W-1:0]   req_pending_word,
   output logic                rsp_valid,
   output logic [2:0]          rsp_kind,
   output logic [LINE_W-1:0]   rsp_service_line,
   output logic [WORD_W-1:0]   rsp_enable_word,
   output logic                rsp_last
);

   localparam int IDX_W = $clog2(NUM_LEVELS + 1);

   state_type            state_ff, state_in;
   logic [NUM_LINES-1:0] est_ff, est_in;
   logic [NUM_LINES-1:0] en_ff, en_in;
   logic [NUM_LINES-1:0] act_ff, act_in;
   logic [NUM_LINES-1:0] bit_ff, bit_in;
   logic [LEVEL_W-1:0]   lvl_ff, lvl_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   kind_type             rsp_kind_ff, rsp_kind_in;
   logic [LINE_W-1:0]    rsp_line_ff, rsp_line_in;
   logic [NUM_LINES-1:0] rsp_en_ff;
   logic                 rsp_last_ff, rsp_last_in;

   mem_ctl_type          mem_ctl;
   logic [NUM_LINES-1:0] mem_wr_data;
   logic [NUM_LINES-1:0] mem_rd_data;

   logic                 scan_start;
   scan_out_type         scan_out;

   logic [NUM_LINES-1:0] dec_bit;
   logic [NUM_LINES-1:0] pend_act;
   logic [NUM_LINES-1:0] masked;
   logic [NUM_LINES-1:0] remain;
   logic                 line_ok;
   logic                 lvl_ok;
   logic                 wr_sel;

   function automatic logic in_chain(input logic [LEVEL_W-1:0] lvl);
      return lvl inside {LVL_BIO, LVL_NET, LVL_TTY, LVL_VM, LVL_CLOCK, LVL_HIGH, LVL_IPI};
   endfunction

   pmid_mask_mem #(
      .NUM_LINES  (NUM_LINES),
      .NUM_LEVELS (NUM_LEVELS)
   ) u_mask_mem (
      .clock   (clock),
      .reset   (reset),
      .mem_ctl (mem_ctl),
      .wr_data (mem_wr_data),
      .rd_data (mem_rd_data)
   );

   pmid_scan #(
      .NUM_LINES (NUM_LINES)
   ) u_scan (
      .clock      (clock),
      .reset      (reset),
      .start      (scan_start),
      .start_word (remain),
      .scan_out   (scan_out)
   );

   always_comb begin
      dec_bit  = NUM_LINES'(1) << req_line;
      pend_act = req_pending_word[NUM_LINES-1:0] & en_ff;
      line_ok  = {1'b0, req_line} < (LINE_W + 1)'(NUM_LINES);
      lvl_ok   = {1'b0, req_priority_level} < (LEVEL_W + 1)'(NUM_LEVELS);
      masked   = act_ff & mem_rd_data;
      remain   = act_ff & ~masked;
   end

   // A registered line joins its own level and, when that level is on the
   // cascade chain, every chain level above it. Level none never keeps bits.
   always_comb begin
      mem_ctl                  = '0;
      mem_ctl.wr_addr          = LEVEL_W'(idx_ff - 1'b1);
      wr_sel = (mem_ctl.wr_addr != LVL_NONE) &&
               ((mem_ctl.wr_addr == lvl_ff) ||
                (in_chain(lvl_ff) && in_chain(mem_ctl.wr_addr) &&
                 (mem_ctl.wr_addr > lvl_ff)));
      mem_wr_data = mem_rd_data | (wr_sel ? bit_ff : '0);

      state_in     = state_ff;
      est_in       = est_ff;
      en_in        = en_ff;
      act_in       = act_ff;
      bit_in       = bit_ff;
      lvl_in       = lvl_ff;
      idx_in       = idx_ff;
      scan_start   = 1'b0;
      rsp_valid_in = 1'b0;
      rsp_kind_in  = KIND_ACK;
      rsp_line_in  = '0;
      rsp_last_in  = 1'b1;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               lvl_in = req_priority_level;
               unique case (req_cmd)
                  CMD_REGISTER: begin
                     if (line_ok && lvl_ok) begin
                        est_in   = est_ff | dec_bit;
                        bit_in   = dec_bit;
                        idx_in   = '0;
                        state_in = ST_SWEEP;
                     end else begin
                        rsp_valid_in = 1'b1;
                     end
                  end
                  CMD_SET_LEVEL: begin
                     mem_ctl.rd_en   = 1'b1;
                     mem_ctl.rd_addr = req_priority_level;
                     state_in        = ST_LEVEL;
                  end
                  CMD_EVENT: begin
                     act_in = pend_act;
                     if (pend_act == '0) begin
                        rsp_valid_in = 1'b1;
                        rsp_kind_in  = KIND_NOT_OURS;
                     end else begin
                        mem_ctl.rd_en   = 1'b1;
                        mem_ctl.rd_addr = req_priority_level;
                        state_in        = ST_EVENT;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SWEEP: begin
            if (idx_ff < IDX_W'(NUM_LEVELS)) begin
               mem_ctl.rd_en   = 1'b1;
               mem_ctl.rd_addr = LEVEL_W'(idx_ff);
               idx_in          = idx_ff + 1'b1;
            end else begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
            if (idx_ff != '0) begin
               mem_ctl.wr_en = 1'b1;
            end
         end
         ST_LEVEL: begin
            en_in        = est_ff & ~mem_rd_data;
            rsp_valid_in = 1'b1;
            rsp_kind_in  = KIND_ENABLE;
            state_in     = ST_IDLE;
         end
         ST_EVENT: begin
            en_in = en_ff & ~masked;
            if (remain == '0) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_ALL_MASKED;
               state_in     = ST_IDLE;
            end else begin
               scan_start = 1'b1;
               state_in   = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_out.valid) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_SERVICE;
               rsp_line_in  = scan_out.line;
               rsp_last_in  = scan_out.last;
               if (scan_out.last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         est_ff       <= '0;
         en_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         est_ff       <= est_in;
         en_ff        <= en_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff      <= act_in;
      bit_ff      <= bit_in;
      lvl_ff      <= lvl_in;
      idx_ff      <= idx_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_line_ff <= rsp_line_in;
      rsp_en_ff   <= en_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign busy             = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kind         = rsp_kind_ff;
   assign rsp_service_line = rsp_line_ff;
   assign rsp_enable_word  = WORD_W'(rsp_en_ff);
   assign rsp_last         = rsp_last_ff;

   `ASSERT_IMPL(a_level_none_stays_clear, clock, reset,
                mem_ctl.wr_en && (mem_ctl.wr_addr == LVL_NONE), mem_wr_data == '0)
   `ASSERT_IMPL(a_scan_only_in_scan_state, clock, reset,
                scan_out.valid, state_ff == ST_SCAN)
   `ASSERT_IMPL(a_idle_scanner_quiet, clock, reset,
                state_ff == ST_IDLE, !scan_out.busy)
   `ASSERT_IMPL(a_single_results_last, clock, reset,
                rsp_valid_ff && (rsp_kind_ff != KIND_SERVICE), rsp_last_ff)

endmodule

// ===== sv/pmid_mask_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmid_mask_mem
// Per-level mask memory: one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module pmid_mask_mem
   import pmid_pkg::*;
#(
   parameter int NUM_LINES  = 64,
   parameter int NUM_LEVELS = 10
) (
   input  logic                 clock,
   input  logic                 reset,
   input  mem_ctl_type          mem_ctl,
   input  logic [NUM_LINES-1:0] wr_data,
   output logic [NUM_LINES-1:0] rd_data
);

   logic [NUM_LINES-1:0]  mem [NUM_LEVELS];
   logic [NUM_LEVELS-1:0] valid_ff;
   logic [NUM_LEVELS-1:0] valid_in;
   logic [NUM_LINES-1:0]  rd_data_ff;
   logic                  rd_hit;

   // Entries never written since reset read as an all-zero mask, as do
   // levels beyond the table.
   always_comb begin
      valid_in = valid_ff;
      if (mem_ctl.wr_en) begin
         valid_in[mem_ctl.wr_addr] = 1'b1;
      end
      rd_hit = ({1'b0, mem_ctl.rd_addr} < (LEVEL_W + 1)'(NUM_LEVELS)) &&
               valid_ff[mem_ctl.rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_ctl.wr_en) begin
         mem[mem_ctl.wr_addr] <= wr_data;
      end
      if (mem_ctl.rd_en) begin
         rd_data_ff <= rd_hit ? mem[mem_ctl.rd_addr] : '0;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/pmid_scan.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// pmid_scan
// Walks an active-line word from the top line down, one line per cycle,
// and reports each set line with a flag on the lowest one.
// ----------------------------------------------------------------------------
module pmid_scan
   import pmid_pkg::*;
#(
   parameter int NUM_LINES = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [NUM_LINES-1:0] start_word,
   output scan_out_type         scan_out
);

   localparam int CNT_W = $clog2(NUM_LINES);

   logic                 run_ff;
   logic                 run_in;
   logic [NUM_LINES-1:0] word_ff;
   logic [NUM_LINES-1:0] word_in;
   logic [CNT_W-1:0]     cnt_ff;
   logic [CNT_W-1:0]     cnt_in;
   logic                 hit;
   logic                 done;

   // The word shifts left each cycle, so the line under test is always
   // the top bit and the counter tracks its line number.
   always_comb begin
      hit     = run_ff && word_ff[NUM_LINES-1];
      done    = hit && (word_ff[NUM_LINES-2:0] == '0);
      run_in  = run_ff;
      word_in = word_ff;
      cnt_in  = cnt_ff;
      if (start) begin
         run_in  = 1'b1;
         word_in = start_word;
         cnt_in  = CNT_W'(NUM_LINES - 1);
      end else if (run_ff) begin
         word_in = word_ff << 1;
         cnt_in  = cnt_ff - 1'b1;
         if (done) begin
            run_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
      end else begin
         run_ff <= run_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
      cnt_ff  <= cnt_in;
   end

   assign scan_out.busy  = run_ff;
   assign scan_out.valid = hit;
   assign scan_out.last  = done;
   assign scan_out.line  = LINE_W'(cnt_ff);

   `ASSERT_IMPL(a_scan_word_nonzero, clock, reset, run_ff, word_ff != '0)
   `ASSERT_NEXT(a_scan_stops_after_last, clock, reset, done && !start, !run_ff)

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the priority masked interrupt dispatch block. A
// shadow model of the mask table, established set and enable register
// predicts every response. Directed tests cover reset state, the mask
// cascade, level selection and event dispatch. A random phase with idle
// bursts follows, and every response is compared field by field in order.
// ----------------------------------------------------------------------------
module tb
   import pmid_pkg::*;
();

   localparam int NUM_LINES    = 64;
   localparam int NUM_LEVELS   = 10;
   localparam int RANDOM_ITEMS = 130;
   localparam int QUIET_ITEMS  = 30;
   localparam int DRAIN_CYCLES = 70;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int REPORT_MAX   = 10;

   localparam logic [CMD_W-1:0]   CMD_UNUSED    = 2'd3;
   localparam logic [LEVEL_W-1:0] LVL_SOFT      = 4'd1;
   localparam logic [LEVEL_W-1:0] LVL_AUDIO     = 4'd6;
   localparam logic [LEVEL_W-1:0] LVL_BEYOND    = 4'd15;
   localparam logic [WORD_W-1:0]  ALL_ONES      = {WORD_W{1'b1}};

   typedef struct {
      kind_type          kind;
      logic [LINE_W-1:0] line;
      logic [WORD_W-1:0] enable_word;
      logic              last;
   } dispatch_rsp_type;

   logic                clock = 1'b0;
   logic                reset;
   logic                start;
   logic                busy;
   logic [CMD_W-1:0]    req_cmd;
   logic [LINE_W-1:0]   req_line;
   logic [LEVEL_W-1:0]  req_priority_level;
   logic [WORD_W-1:0]   req_pending_word;
   logic                rsp_valid;
   logic [2:0]          rsp_kind;
   logic [LINE_W-1:0]   rsp_service_line;
   logic [WORD_W-1:0]   rsp_enable_word;
   logic                rsp_last;

   // Shadow copy of the block state.
   logic [WORD_W-1:0] shadow_masks [0:NUM_LEVELS-1];
   logic [WORD_W-1:0] shadow_established;
   logic [WORD_W-1:0] shadow_enable;

   dispatch_rsp_type expected_rsp_q[$];

   int mismatch_count = 0;
   int request_count  = 0;
   int response_count = 0;
   int service_count  = 0;
   int cycle_count    = 0;
   bit quiet_sender   = 1'b0;

   priority_masked_interrupt_dispatch #(
      .NUM_LINES  (NUM_LINES),
      .NUM_LEVELS (NUM_LEVELS)
   ) dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_cmd            (req_cmd),
      .req_line           (req_line),
      .req_priority_level (req_priority_level),
      .req_pending_word   (req_pending_word),
      .rsp_valid          (rsp_valid),
      .rsp_kind           (rsp_kind),
      .rsp_service_line   (rsp_service_line),
      .rsp_enable_word    (rsp_enable_word),
      .rsp_last           (rsp_last)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d responses outstanding", cycle_count,
                  expected_rsp_q.size());
         $display("Verification failed");
         $finish;
      end
   end

   function automatic void push_expected(kind_type kind, logic [LINE_W-1:0] line,
                                         logic last);
      dispatch_rsp_type item;
      item.kind        = kind;
      item.line        = line;
      item.enable_word = shadow_enable;
      item.last        = last;
      expected_rsp_q.push_back(item);
   endfunction

   // Computes the responses of one accepted request and updates the shadow state.
   function automatic void predict_dispatch(logic [CMD_W-1:0] cmd, logic [LINE_W-1:0] line,
                                            logic [LEVEL_W-1:0] lvl,
                                            logic [WORD_W-1:0] pend);
      logic [WORD_W-1:0] lvl_mask;
      logic [WORD_W-1:0] active;
      logic [WORD_W-1:0] masked;
      lvl_mask = (lvl < NUM_LEVELS) ? shadow_masks[lvl] : '0;
      case (cmd)
         CMD_REGISTER: begin
            if (lvl < NUM_LEVELS) begin
               shadow_established |= 64'd1 << line;
               shadow_masks[lvl]  |= 64'd1 << line;
               shadow_masks[LVL_NET]   |= shadow_masks[LVL_BIO];
               shadow_masks[LVL_TTY]   |= shadow_masks[LVL_NET];
               shadow_masks[LVL_VM]    |= shadow_masks[LVL_TTY];
               shadow_masks[LVL_CLOCK] |= shadow_masks[LVL_VM];
               shadow_masks[LVL_HIGH]  |= shadow_masks[LVL_CLOCK];
               shadow_masks[LVL_IPI]   |= shadow_masks[LVL_HIGH];
               shadow_masks[LVL_NONE]   = '0;
            end
            push_expected(KIND_ACK, '0, 1'b1);
         end
         CMD_SET_LEVEL: begin
            shadow_enable = shadow_established & ~lvl_mask;
            push_expected(KIND_ENABLE, '0, 1'b1);
         end
         CMD_EVENT: begin
            active = pend & shadow_enable;
            if (active == '0) begin
               push_expected(KIND_NOT_OURS, '0, 1'b1);
            end else begin
               masked        = active & lvl_mask;
               active        = active & ~masked;
               shadow_enable = shadow_enable & ~masked;
               if (active == '0) begin
                  push_expected(KIND_ALL_MASKED, '0, 1'b1);
               end else begin
                  for (int b = WORD_W - 1; b >= 0; b--) begin
                     if (active[b]) begin
                        active[b] = 1'b0;
                        push_expected(KIND_SERVICE, b[LINE_W-1:0], active == '0);
                     end
                  end
               end
            end
         end
         default: begin
            // The unused command leaves everything alone and answers nothing.
         end
      endcase
   endfunction

   function automatic void note_mismatch(string what);
      mismatch_count++;
      if (mismatch_count <= REPORT_MAX)
         $display("Mismatch at cycle %0d: %s", cycle_count, what);
   endfunction

   // Response checker: each strobe is matched against the oldest expectation.
   always @(posedge clock) begin
      dispatch_rsp_type exp_rsp;
      if (!reset && rsp_valid === 1'b1) begin
         response_count++;
         if (expected_rsp_q.size() == 0) begin
            note_mismatch($sformatf("unexpected response kind=%0d line=%0d enable=%h last=%b",
                                    rsp_kind, rsp_service_line, rsp_enable_word, rsp_last));
         end else begin
            exp_rsp = expected_rsp_q.pop_front();
            if (exp_rsp.kind == KIND_SERVICE)
               service_count++;
            if (rsp_kind !== exp_rsp.kind || rsp_service_line !== exp_rsp.line ||
                rsp_enable_word !== exp_rsp.enable_word || rsp_last !== exp_rsp.last)
               note_mismatch($sformatf(
                  {"expected kind=%0d line=%0d enable=%h last=%b, ",
                   "got kind=%0d line=%0d enable=%h last=%b"},
                  exp_rsp.kind, exp_rsp.line, exp_rsp.enable_word, exp_rsp.last,
                  rsp_kind, rsp_service_line, rsp_enable_word, rsp_last));
         end
      end
   end

   // Presents one request and holds it until the block takes the transfer.
   task automatic send_request(logic [CMD_W-1:0] cmd, logic [LINE_W-1:0] line,
                               logic [LEVEL_W-1:0] lvl, logic [WORD_W-1:0] pend);
      @(negedge clock);
      start              <= 1'b1;
      req_cmd            <= cmd;
      req_line           <= line;
      req_priority_level <= lvl;
      req_pending_word   <= pend;
      do
         @(posedge clock);
      while (busy !== 1'b0);
      predict_dispatch(cmd, line, lvl, pend);
      request_count++;
   endtask

   task automatic idle_sender(int cycles);
      repeat (cycles) begin
         @(negedge clock);
         start <= 1'b0;
      end
   endtask

   task automatic maybe_idle();
      if (!quiet_sender && $urandom_range(0, 3) == 0)
         idle_sender($urandom_range(1, 4));
   endtask

   task automatic wait_for_responses();
      while (expected_rsp_q.size() != 0)
         @(posedge clock);
   endtask

   task automatic test_reset_state();
      send_request(CMD_SET_LEVEL, 6'd0, LVL_NONE, '0);
      send_request(CMD_EVENT, 6'd0, LVL_NONE, ALL_ONES);
      send_request(CMD_UNUSED, 6'd63, LVL_BEYOND, ALL_ONES);
   endtask

   task automatic test_registration();
      send_request(CMD_REGISTER, 6'd63, LVL_BIO, '0);
      maybe_idle();
      send_request(CMD_REGISTER, 6'd0, LVL_NONE, ALL_ONES);
      send_request(CMD_REGISTER, 6'd1, LVL_IPI, '0);
      maybe_idle();
      send_request(CMD_REGISTER, 6'd32, LVL_SOFT, '0);
      send_request(CMD_REGISTER, 6'd40, LVL_AUDIO, '0);
      // A level beyond the table is acknowledged but registers nothing.
      send_request(CMD_REGISTER, 6'd5, LVL_BEYOND, '0);
      send_request(CMD_REGISTER, 6'd7, LVL_TTY, '0);
   endtask

   task automatic test_level_select();
      send_request(CMD_SET_LEVEL, 6'd0, LVL_NONE, '0);
      send_request(CMD_SET_LEVEL, 6'd63, LVL_BIO, ALL_ONES);
      maybe_idle();
      send_request(CMD_SET_LEVEL, 6'd0, LVL_IPI, '0);
      send_request(CMD_SET_LEVEL, 6'd0, LVL_BEYOND, '0);
   endtask

   task automatic test_event_dispatch();
      send_request(CMD_SET_LEVEL, 6'd0, LVL_NONE, '0);
      send_request(CMD_EVENT, 6'd0, LVL_NONE, ALL_ONES);
      send_request(CMD_SET_LEVEL, 6'd0, LVL_NONE, '0);
      // The highest level masks the cascaded lines and services the rest.
      send_request(CMD_EVENT, 6'd0, LVL_IPI, ALL_ONES);
      send_request(CMD_EVENT, 6'd0, LVL_BIO, 64'd1 << 63);
      maybe_idle();
      send_request(CMD_SET_LEVEL, 6'd0, LVL_NONE, '0);
      send_request(CMD_EVENT, 6'd0, LVL_BIO, 64'd1 << 63);
      send_request(CMD_EVENT, 6'd0, LVL_NONE, '0);
      send_request(CMD_SET_LEVEL, 6'd0, LVL_AUDIO, '0);
      send_request(CMD_EVENT, 6'd0, LVL_BEYOND, ALL_ONES);
   endtask

   task automatic test_random_traffic();
      int counted;
      int sel;
      logic [LEVEL_W-1:0] lvl;
      logic [WORD_W-1:0]  pend;
      counted = 0;
      while (counted < RANDOM_ITEMS) begin
         sel = $urandom_range(0, 99);
         lvl = ($urandom_range(0, 9) == 0) ? LEVEL_W'($urandom_range(NUM_LEVELS, 15))
                                           : LEVEL_W'($urandom_range(0, NUM_LEVELS - 1));
         pend = {$urandom, $urandom};
         quiet_sender = (counted >= RANDOM_ITEMS - QUIET_ITEMS);
         if (counted < 24 || sel < 30) begin
            send_request(CMD_REGISTER, LINE_W'($urandom_range(0, NUM_LINES - 1)), lvl, pend);
            counted++;
         end else if (sel < 55) begin
            send_request(CMD_SET_LEVEL, LINE_W'($urandom_range(0, NUM_LINES - 1)),
                         LEVEL_W'($urandom_range(0, 15)), pend);
            counted++;
         end else if (sel < 95) begin
            case ($urandom_range(0, 5))
               0: pend = ALL_ONES;
               1: pend = 64'd1 << $urandom_range(0, 63);
               2: pend = '0;
               3: pend = pend & {$urandom, $urandom};
               4: pend = shadow_enable;
               default: ;
            endcase
            send_request(CMD_EVENT, LINE_W'($urandom_range(0, NUM_LINES - 1)),
                         LEVEL_W'($urandom_range(0, 15)), pend);
            counted++;
         end else begin
            send_request(CMD_UNUSED, LINE_W'($urandom_range(0, NUM_LINES - 1)),
                         LEVEL_W'($urandom_range(0, 15)), pend);
         end
         // Halfway through, hold off until the block has answered everything.
         if (counted == RANDOM_ITEMS / 2 && sel < 95) begin
            idle_sender(1);
            wait_for_responses();
         end
         maybe_idle();
      end
   endtask

   initial begin
      reset              = 1'b1;
      start              = 1'b0;
      req_cmd            = CMD_REGISTER;
      req_line           = '0;
      req_priority_level = LVL_NONE;
      req_pending_word   = '0;
      for (int i = 0; i < NUM_LEVELS; i++)
         shadow_masks[i] = '0;
      shadow_established = '0;
      shadow_enable      = '0;
      repeat (2) @(negedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_registration();
      test_level_select();
      test_event_dispatch();
      test_random_traffic();

      idle_sender(1);
      wait_for_responses();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d requests covering registration, level select and events;",
               request_count);
      $display("checked %0d responses, %0d of them service lines, with %0d mismatches.",
               response_count, service_count, mismatch_count);
      if (mismatch_count == 0 && expected_rsp_q.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// ===== priority_masked_interrupt_dispatch.f =====
+incdir+sv
sv/pmid_pkg.sv
sv/pmid_mask_mem.sv
sv/pmid_scan.sv
sv/priority_masked_interrupt_dispatch.sv
sim/tb.sv
